[hw/rtl/pfa_pkg.sv]
package pfa_pkg;

  // item fields
  localparam int PID_IN_W    = 6;
  localparam int FRAME_OUT_W = 8;
  localparam int PAGE_OUT_W  = 4;
  localparam int CNT_OUT_W   = 32;
  localparam int STATUS_W    = 3;

  // stream widths
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 80;
  localparam int M_PAD_W   = M_TDATA_W - (FRAME_OUT_W + PAGE_OUT_W + 2 * CNT_OUT_W);

  // configuration registers
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 9;
  localparam int PPP_W       = 5;
  localparam int TF_W        = 9;

  localparam logic [CFG_INDEX_W-1:0] CFG_PAGES_PER_PROCESS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_FRAMES      = 1'b1;

  localparam logic [PPP_W-1:0] PPP_RESET = 5'd4;
  localparam int               TF_RESET  = 256;

  // request kinds
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_GRANTED      = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_RESIDENT     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_SPACE     = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FREED        = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NOT_RESIDENT = 3'd4;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [FRAME_OUT_W-1:0] frame;
    logic [PAGE_OUT_W-1:0]  page;
    logic                   last;
    logic [CNT_OUT_W-1:0]   pages_in_total;
    logic [CNT_OUT_W-1:0]   pages_out_total;
  } result_t;

  typedef struct packed {
    logic active;
    logic clear_tables;
  } sweep_status_t;

endpackage

[hw/rtl/paged_frame_allocator_unit.sv]
// paged frame allocator: free frame queue plus a page table per process slot
// input channel s_*: one request item, s_tuser = command (0 allocate, 1 free),
//   s_tdata = process slot; taken only when the block is idle
// output channel m_*: one result item per page moved, or a single item for
//   already resident, no space or not resident; m_tlast marks the final one
// config channel cfg_*: index 0 pages_per_process, 1 total_frames; always ready,
//   write only while no request is in flight
// a taken request is looked up first; a single result is issued from the lookup,
//   while a request moving pages hands them to the sequencer, which handles
//   one page per cycle through the queue and page table memories (one read and
//   one write port each) while m_tready does not stall
// at reset, and after each total_frames write, a fill pass over
//   max(FRAMES, PROCESSES) indices rewrites the free queue (and at reset clears
//   the process table); no request is taken during it
// a stalled m_tready holds the current result and freezes the sequencer
module paged_frame_allocator_unit #(
  parameter int FRAMES    = 256,
  parameter int PROCESSES = 64,
  parameter int PAGES_MAX = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [pfa_pkg::S_TDATA_W-1:0]        s_tdata,  // process_id [5:0], zero [7:6]
  input  logic [0:0]                           s_tuser,  // command [0]
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // frame [7:0], page [11:8], pages_in_total [43:12], pages_out_total [75:44], zero [79:76]
  output logic [pfa_pkg::M_TDATA_W-1:0]        m_tdata,
  output logic [pfa_pkg::STATUS_W-1:0]         m_tuser,  // status [2:0]
  output logic                                 m_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pfa_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [pfa_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int FR_W     = $clog2(FRAMES);
  localparam int QC_W     = $clog2(FRAMES + 1);
  localparam int PID_W    = $clog2(PROCESSES);
  localparam int CNT_W    = $clog2(PAGES_MAX + 1);
  localparam int PG_W     = (PAGES_MAX > 1) ? $clog2(PAGES_MAX) : 1;
  localparam int PF_DEPTH = PROCESSES * PAGES_MAX;
  localparam int PF_AW    = $clog2(PF_DEPTH);
  localparam int SWEEP_N  = (FRAMES > PROCESSES) ? FRAMES : PROCESSES;
  localparam int SW_W     = $clog2(SWEEP_N);
  localparam int TW       = (QC_W > pfa_pkg::TF_W) ? QC_W : pfa_pkg::TF_W;
  localparam int TF_SAT   = (pfa_pkg::TF_RESET > FRAMES) ? FRAMES : pfa_pkg::TF_RESET;
  localparam int PID_IN_N = 2 ** pfa_pkg::PID_IN_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_ALLOC  = 4'b0100,
    ST_FREE   = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [pfa_pkg::PPP_W-1:0]     pages_per_process;
  logic                          cmd;
  logic [PID_W-1:0]              pid;
  logic [PG_W-1:0]               page, page_next;
  logic [CNT_W-1:0]              n_pages, n_pages_next;
  logic [FR_W-1:0]               head, head_next;
  logic [QC_W-1:0]               count, count_next;
  logic [pfa_pkg::CNT_OUT_W-1:0] pages_in, pages_in_next;
  logic [pfa_pkg::CNT_OUT_W-1:0] pages_out, pages_out_next;
  logic                          out_valid;
  pfa_pkg::result_t              out_item, emit_item;
  logic                          emit;

  logic                          in_accept, cfg_accept, refill;
  logic [PID_W-1:0]              pid_map [PID_IN_N];
  logic [PID_W-1:0]              pid_in;
  logic [CNT_W-1:0]              n_eff;
  logic [QC_W-1:0]               refill_count;
  logic [TW-1:0]                 tf_ext;
  logic [CNT_W-1:0]              page_inc;
  logic                          page_last;
  logic                          out_free;
  logic [QC_W:0]                 tail_sum;
  logic [FR_W-1:0]               tail;

  pfa_pkg::sweep_status_t        sweep;
  logic [SW_W-1:0]               sweep_idx;
  logic                          sweep_q_we, sweep_o_we;

  logic                          q_we;
  logic [FR_W-1:0]               q_waddr, q_wdata, q_rdata;
  logic                          pf_we;
  logic [PF_AW-1:0]              pf_base, pf_waddr, pf_raddr;
  logic [FR_W-1:0]               pf_rdata;
  logic                          o_we;
  logic [PID_W-1:0]              o_waddr, o_raddr;
  logic [CNT_W-1:0]              o_wdata, o_rdata;

  // slot number folded into the process range
  for (genvar g = 0; g < PID_IN_N; g++) begin : g_pid_map
    assign pid_map[g] = PID_W'(g % PROCESSES);
  end

  assign pid_in     = pid_map[s_tdata[pfa_pkg::PID_IN_W-1:0]];
  assign s_tready   = (state == ST_IDLE) && !sweep.active;
  assign in_accept  = s_tvalid && s_tready;
  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid && cfg_ready;
  assign refill     = cfg_accept && (cfg_index == pfa_pkg::CFG_TOTAL_FRAMES);
  assign out_free   = !out_valid || m_tready;

  assign tf_ext       = TW'(cfg_data);
  assign refill_count = (tf_ext > TW'(FRAMES)) ? QC_W'(FRAMES) : QC_W'(tf_ext);

  always_comb begin
    if (pages_per_process == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(pages_per_process) > PAGES_MAX) begin
      n_eff = CNT_W'(PAGES_MAX);
    end else begin
      n_eff = CNT_W'(pages_per_process);
    end
  end

  assign page_inc  = CNT_W'(page) + CNT_W'(1);
  assign page_last = (page_inc == n_pages);

  // tail position of the circular queue
  assign tail_sum = (QC_W + 1)'(head) + (QC_W + 1)'(count);
  assign tail     = (tail_sum >= (QC_W + 1)'(FRAMES)) ?
                    FR_W'(tail_sum - (QC_W + 1)'(FRAMES)) : FR_W'(tail_sum);

  assign pf_base = PF_AW'(pid * PAGES_MAX);

  always_comb begin
    state_next     = state;
    page_next      = page;
    n_pages_next   = n_pages;
    head_next      = head;
    count_next     = count;
    pages_in_next  = pages_in;
    pages_out_next = pages_out;
    emit           = 1'b0;
    emit_item      = '{status: pfa_pkg::STAT_GRANTED, frame: '0, page: '0, last: 1'b1,
                       pages_in_total: pages_in, pages_out_total: pages_out};
    q_we           = 1'b0;
    q_waddr        = tail;
    q_wdata        = pf_rdata;
    pf_we          = 1'b0;
    o_we           = 1'b0;
    o_waddr        = pid;
    o_wdata        = '0;

    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        page_next = '0;
        if (cmd == pfa_pkg::CMD_ALLOC) begin
          if (o_rdata != '0) begin
            emit_item.status = pfa_pkg::STAT_RESIDENT;
            emit             = out_free;
            if (out_free) state_next = ST_IDLE;
          end else if (count < QC_W'(n_eff)) begin
            emit_item.status = pfa_pkg::STAT_NO_SPACE;
            emit             = out_free;
            if (out_free) state_next = ST_IDLE;
          end else begin
            n_pages_next = n_eff;
            state_next   = ST_ALLOC;
          end
        end else begin
          if (o_rdata == '0) begin
            emit_item.status = pfa_pkg::STAT_NOT_RESIDENT;
            emit             = out_free;
            if (out_free) state_next = ST_IDLE;
          end else begin
            n_pages_next = o_rdata;
            state_next   = ST_FREE;
          end
        end
      end
      ST_ALLOC: begin
        emit_item = '{status: pfa_pkg::STAT_GRANTED,
                      frame: pfa_pkg::FRAME_OUT_W'(q_rdata),
                      page: pfa_pkg::PAGE_OUT_W'(page), last: page_last,
                      pages_in_total: pages_in + 32'd1, pages_out_total: pages_out};
        if (out_free) begin
          emit          = 1'b1;
          pages_in_next = pages_in + 32'd1;
          head_next     = (head == FR_W'(FRAMES - 1)) ? '0 : head + FR_W'(1);
          count_next    = count - QC_W'(1);
          pf_we         = 1'b1;
          if (page_last) begin
            o_we       = 1'b1;
            o_wdata    = n_pages;
            state_next = ST_IDLE;
          end else begin
            page_next = page + PG_W'(1);
          end
        end
      end
      ST_FREE: begin
        emit_item = '{status: pfa_pkg::STAT_FREED,
                      frame: pfa_pkg::FRAME_OUT_W'(pf_rdata),
                      page: pfa_pkg::PAGE_OUT_W'(page), last: page_last,
                      pages_in_total: pages_in, pages_out_total: pages_out + 32'd1};
        if (out_free) begin
          emit           = 1'b1;
          pages_out_next = pages_out + 32'd1;
          // a full queue drops the frame but still reports it
          if (count < QC_W'(FRAMES)) begin
            q_we       = 1'b1;
            count_next = count + QC_W'(1);
          end
          if (page_last) begin
            o_we       = 1'b1;
            o_wdata    = '0;
            state_next = ST_IDLE;
          end else begin
            page_next = page + PG_W'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (refill) begin
      head_next  = '0;
      count_next = refill_count;
    end

    // fill pass overrides the queue and owned table write ports
    if (sweep_q_we) begin
      q_we    = 1'b1;
      q_waddr = sweep_idx[FR_W-1:0];
      q_wdata = sweep_idx[FR_W-1:0];
    end
    if (sweep_o_we) begin
      o_we    = 1'b1;
      o_waddr = sweep_idx[PID_W-1:0];
      o_wdata = '0;
    end
  end

  assign sweep_q_we = sweep.active && ((SW_W + 1)'(sweep_idx) < (SW_W + 1)'(FRAMES));
  assign sweep_o_we = sweep.active && sweep.clear_tables &&
                      ((SW_W + 1)'(sweep_idx) < (SW_W + 1)'(PROCESSES));

  assign pf_waddr = pf_base + PF_AW'(page);
  assign pf_raddr = pf_base + PF_AW'(page_next);
  assign o_raddr  = (state == ST_IDLE) ? pid_in : pid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      pages_per_process <= pfa_pkg::PPP_RESET;
      head              <= '0;
      count             <= QC_W'(TF_SAT);
      pages_in          <= '0;
      pages_out         <= '0;
      out_valid         <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      pages_in  <= pages_in_next;
      pages_out <= pages_out_next;
      if (cfg_accept && cfg_index == pfa_pkg::CFG_PAGES_PER_PROCESS) begin
        pages_per_process <= cfg_data[pfa_pkg::PPP_W-1:0];
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    page    <= page_next;
    n_pages <= n_pages_next;
    if (in_accept) begin
      cmd <= s_tuser[0];
      pid <= pid_in;
    end
    if (emit) begin
      out_item <= emit_item;
    end
  end

  pfa_sweep #(
    .LENGTH (SWEEP_N)
  ) u_sweep (
    .clk     (clk),
    .rst     (rst),
    .restart (refill),
    .status  (sweep),
    .idx     (sweep_idx)
  );

  // free frame queue
  pfa_ram #(
    .WIDTH (FR_W),
    .DEPTH (FRAMES)
  ) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (head_next),
    .rdata (q_rdata)
  );

  // frame of each page of each process
  pfa_ram #(
    .WIDTH (FR_W),
    .DEPTH (PF_DEPTH)
  ) u_page_frames (
    .clk   (clk),
    .we    (pf_we),
    .waddr (pf_waddr),
    .wdata (q_rdata),
    .raddr (pf_raddr),
    .rdata (pf_rdata)
  );

  // pages owned per process, zero when not resident
  pfa_ram #(
    .WIDTH (CNT_W),
    .DEPTH (PROCESSES)
  ) u_owned (
    .clk   (clk),
    .we    (o_we),
    .waddr (o_waddr),
    .wdata (o_wdata),
    .raddr (o_raddr),
    .rdata (o_rdata)
  );

  assign m_tvalid = out_valid;
  assign m_tuser  = out_item.status;
  assign m_tlast  = out_item.last;
  assign m_tdata  = {{pfa_pkg::M_PAD_W{1'b0}}, out_item.pages_out_total,
                     out_item.pages_in_total, out_item.page, out_item.frame};

endmodule

[hw/rtl/pfa_ram.sv]
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/pfa_sweep.sv]
module pfa_sweep #(
  parameter int LENGTH = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      restart,
  output pfa_pkg::sweep_status_t    status,
  output logic [$clog2(LENGTH)-1:0] idx
);

  localparam int IW = $clog2(LENGTH);

  logic active;
  logic clear_tables;

  // reset clears the process table and fills the queue; a refill only fills the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b1;
      clear_tables <= 1'b1;
      idx          <= '0;
    end else if (restart) begin
      active <= 1'b1;
      idx    <= '0;
    end else if (active) begin
      if (idx == IW'(LENGTH - 1)) begin
        active       <= 1'b0;
        clear_tables <= 1'b0;
      end else begin
        idx <= idx + IW'(1);
      end
    end
  end

  assign status.active       = active;
  assign status.clear_tables = clear_tables;

endmodule

[tb/sv/paged_frame_allocator_unit_tb.sv]
`timescale 1ns / 100ps

module paged_frame_allocator_unit_tb;

  localparam int FRAMES        = 256;
  localparam int PROCESSES     = 64;
  localparam int PAGES_MAX     = 16;
  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_ITEMS  = 350;
  localparam int PHASES        = 7;
  localparam int DIR_ROWS      = 30;

  localparam int PAGE_LSB = pfa_pkg::FRAME_OUT_W;
  localparam int IN_LSB   = PAGE_LSB + pfa_pkg::PAGE_OUT_W;
  localparam int OUT_LSB  = IN_LSB + pfa_pkg::CNT_OUT_W;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // sel is the command for a request row, the register index for a write row
  typedef struct packed {
    row_kind_t                    kind;
    logic                         sel;
    logic [9:0]                   value;
    logic                         typed;
    logic [pfa_pkg::STATUS_W-1:0] st;
    logic [7:0]                   fr;
  } stim_row_t;

  // typed rows give status and frame of the first result item only
  stim_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_REQ, pfa_pkg::CMD_FREE,  10'd0,  1'b1, pfa_pkg::STAT_NOT_RESIDENT, 8'd0},
    '{ROW_REQ, pfa_pkg::CMD_ALLOC, 10'd0,  1'b1, pfa_pkg::STAT_GRANTED,      8'd0},
    '{ROW_REQ, pfa_pkg::CMD_ALLOC, 10'd0,  1'b1, pfa_pkg::STAT_RESIDENT,     8'd0},
    '{ROW_REQ, pfa_pkg::CMD_ALLOC, 10'd63, 1'b1, pfa_pkg::STAT_GRANTED,      8'd4},
    '{ROW_REQ, pfa_pkg::CMD_FREE,  10'd0,  1'b1, pfa_pkg::STAT_FREED,        8'd0},
    '{ROW_REQ, pfa_pkg::CMD_FREE,  10'd0,  1'b1, pfa_pkg::STAT_NOT_RESIDENT, 8'd0},
    '{ROW_REQ, pfa_pkg::CMD_FREE,  10'd63, 1'b1, pfa_pkg::STAT_FREED,        8'd4},
    '{ROW_REQ, pfa_pkg::CMD_ALLOC, 10'd42, 1'b0, pfa_pkg::STAT_GRANTED,      8'd0},
    '{ROW_REQ, pfa_pkg::CMD_ALLOC, 10'd21, 1'b0, pfa_pkg::STAT_GRANTED,      8'd0},
    '{ROW_REQ, pfa_pkg::CMD_FREE,  10'd42, 1'b0, pfa_pkg::STAT_GRANTED,      8'd0},
    // page count above the maximum, small memory
    '{ROW_CFG, pfa_pkg::CFG_PAGES_PER_PROCESS, 10'd31, 1'b0, pfa_pkg::STAT_GRANTED, 8'd0},
    '{ROW_CFG, pfa_pkg::CFG_TOTAL_FRAMES,      10'd40, 1'b0, pfa_pkg::STAT_GRANTED, 8'd0},
    '{ROW_REQ, pfa_pkg::CMD_ALLOC, 10'd1,  1'b1, pfa_pkg::STAT_GRANTED,      8'd0},
    '{ROW_REQ, pfa_pkg::CMD_ALLOC, 10'd2,  1'b1, pfa_pkg::STAT_GRANTED,      8'd16},
    '{ROW_REQ, pfa_pkg::CMD_ALLOC, 10'd3,  1'b1, pfa_pkg::STAT_NO_SPACE,     8'd0},
    '{ROW_REQ, pfa_pkg::CMD_FREE,  10'd1,  1'b0, pfa_pkg::STAT_GRANTED,      8'd0},
    '{ROW_REQ, pfa_pkg::CMD_ALLOC, 10'd3,  1'b0, pfa_pkg::STAT_GRANTED,      8'd0},
    // empty memory
    '{ROW_CFG, pfa_pkg::CFG_TOTAL_FRAMES,      10'd0,  1'b0, pfa_pkg::STAT_GRANTED, 8'd0},
    '{ROW_REQ, pfa_pkg::CMD_ALLOC, 10'd5,  1'b1, pfa_pkg::STAT_NO_SPACE,     8'd0},
    '{ROW_REQ, pfa_pkg::CMD_FREE,  10'd2,  1'b0, pfa_pkg::STAT_GRANTED,      8'd0},
    // zero page count, oversized memory, then a free into a full queue
    '{ROW_CFG, pfa_pkg::CFG_PAGES_PER_PROCESS, 10'd0,   1'b0, pfa_pkg::STAT_GRANTED, 8'd0},
    '{ROW_CFG, pfa_pkg::CFG_TOTAL_FRAMES,      10'd511, 1'b0, pfa_pkg::STAT_GRANTED, 8'd0},
    '{ROW_REQ, pfa_pkg::CMD_FREE,  10'd3,  1'b0, pfa_pkg::STAT_GRANTED,      8'd0},
    '{ROW_REQ, pfa_pkg::CMD_ALLOC, 10'd7,  1'b1, pfa_pkg::STAT_GRANTED,      8'd0},
    '{ROW_CFG, pfa_pkg::CFG_PAGES_PER_PROCESS, 10'd1, 1'b0, pfa_pkg::STAT_GRANTED, 8'd0},
    '{ROW_CFG, pfa_pkg::CFG_TOTAL_FRAMES,      10'd1, 1'b0, pfa_pkg::STAT_GRANTED, 8'd0},
    '{ROW_REQ, pfa_pkg::CMD_ALLOC, 10'd8,  1'b1, pfa_pkg::STAT_GRANTED,      8'd0},
    '{ROW_REQ, pfa_pkg::CMD_ALLOC, 10'd9,  1'b1, pfa_pkg::STAT_NO_SPACE,     8'd0},
    '{ROW_REQ, pfa_pkg::CMD_FREE,  10'd21, 1'b0, pfa_pkg::STAT_GRANTED,      8'd0},
    '{ROW_REQ, pfa_pkg::CMD_FREE,  10'd8,  1'b0, pfa_pkg::STAT_GRANTED,      8'd0}
  };

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [pfa_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
  logic [0:0]                      s_tuser   = '0;
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [pfa_pkg::M_TDATA_W-1:0]   m_tdata;
  logic [pfa_pkg::STATUS_W-1:0]    m_tuser;
  logic                            m_tlast;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [pfa_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [pfa_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  // typed expectation travelling with the item on the request channel
  logic                         cur_typed = 1'b0;
  logic [pfa_pkg::STATUS_W-1:0] cur_st    = '0;
  logic [7:0]                   cur_fr    = '0;

  bit idling = 1'b1;
  int stall_left;
  int errors;
  int n_alloc;
  int n_free;
  int n_cfg;
  int n_checked;
  int stat_seen [8];

  // allocator state as predicted
  logic [7:0]                free_q [FRAMES];
  logic [7:0]                free_head;
  logic [8:0]                free_count;
  logic [7:0]                page_tab [PROCESSES*PAGES_MAX];
  bit                        resident_tab [PROCESSES];
  logic [4:0]                owned_tab [PROCESSES];
  logic [31:0]               granted_cnt;
  logic [31:0]               returned_cnt;
  logic [pfa_pkg::PPP_W-1:0] ppp_reg;
  logic [pfa_pkg::TF_W-1:0]  tf_reg;

  pfa_pkg::result_t frame_reports_due [$];

  paged_frame_allocator_unit #(
    .FRAMES   (FRAMES),
    .PROCESSES(PROCESSES),
    .PAGES_MAX(PAGES_MAX)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  function automatic void refill_free_list();
    for (int i = 0; i < FRAMES; i++) free_q[i] = i[7:0];
    free_head  = '0;
    free_count = (tf_reg > FRAMES) ? 9'(FRAMES) : tf_reg;
  endfunction

  function automatic void queue_report(logic [pfa_pkg::STATUS_W-1:0] st, logic [7:0] fr,
                                       logic [3:0] pg, logic last);
    pfa_pkg::result_t r;
    r.status          = st;
    r.frame           = fr;
    r.page            = pg;
    r.last            = last;
    r.pages_in_total  = granted_cnt;
    r.pages_out_total = returned_cnt;
    frame_reports_due = {frame_reports_due, r};
  endfunction

  function automatic void predict_frame_moves(logic cmd, logic [5:0] pid);
    int n;
    int base;
    logic [7:0] f;
    base = int'(pid) * PAGES_MAX;
    if (cmd == pfa_pkg::CMD_ALLOC) begin
      if (resident_tab[pid]) begin
        queue_report(pfa_pkg::STAT_RESIDENT, '0, '0, 1'b1);
        return;
      end
      n = (ppp_reg == 0) ? 1 : ((ppp_reg > PAGES_MAX) ? PAGES_MAX : int'(ppp_reg));
      if (int'(free_count) < n) begin
        queue_report(pfa_pkg::STAT_NO_SPACE, '0, '0, 1'b1);
        return;
      end
      for (int i = 0; i < n; i++) begin
        f = free_q[free_head];
        free_head  = free_head + 8'd1;
        free_count = free_count - 9'd1;
        page_tab[base + i] = f;
        granted_cnt = granted_cnt + 32'd1;
        queue_report(pfa_pkg::STAT_GRANTED, f, i[3:0], i == n - 1);
      end
      resident_tab[pid] = 1'b1;
      owned_tab[pid]    = n[4:0];
    end else begin
      if (!resident_tab[pid]) begin
        queue_report(pfa_pkg::STAT_NOT_RESIDENT, '0, '0, 1'b1);
        return;
      end
      n = int'(owned_tab[pid]);
      for (int i = 0; i < n; i++) begin
        f = page_tab[base + i];
        // a full queue drops the frame but it still counts as freed
        if (free_count < FRAMES) begin
          free_q[8'(free_head + free_count[7:0])] = f;
          free_count = free_count + 9'd1;
        end
        returned_cnt = returned_cnt + 32'd1;
        queue_report(pfa_pkg::STAT_FREED, f, i[3:0], i == n - 1);
      end
      resident_tab[pid] = 1'b0;
      owned_tab[pid]    = '0;
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // result checking, register tracking and prediction on accepted items
  always @(posedge clk) begin
    pfa_pkg::result_t got;
    pfa_pkg::result_t want;
    int first;
    if (rst) begin
      ppp_reg      = pfa_pkg::PPP_RESET;
      tf_reg       = pfa_pkg::TF_W'(pfa_pkg::TF_RESET);
      refill_free_list();
      for (int i = 0; i < PROCESSES; i++) begin
        resident_tab[i] = 1'b0;
        owned_tab[i]    = '0;
      end
      granted_cnt  = '0;
      returned_cnt = '0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status          = m_tuser;
        got.frame           = m_tdata[0 +: pfa_pkg::FRAME_OUT_W];
        got.page            = m_tdata[PAGE_LSB +: pfa_pkg::PAGE_OUT_W];
        got.last            = m_tlast;
        got.pages_in_total  = m_tdata[IN_LSB +: pfa_pkg::CNT_OUT_W];
        got.pages_out_total = m_tdata[OUT_LSB +: pfa_pkg::CNT_OUT_W];
        stat_seen[got.status]++;
        if (frame_reports_due.size() == 0) begin
          $error("result item with nothing expected: status %0d frame %0d",
                 got.status, got.frame);
          errors++;
        end else begin
          want = frame_reports_due.pop_front();
          n_checked++;
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("frame", 32'(want.frame), 32'(got.frame));
          check_field("page", 32'(want.page), 32'(got.page));
          check_field("last", 32'(want.last), 32'(got.last));
          check_field("pages_in_total", want.pages_in_total, got.pages_in_total);
          check_field("pages_out_total", want.pages_out_total, got.pages_out_total);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pfa_pkg::CFG_PAGES_PER_PROCESS) begin
          ppp_reg = cfg_data[pfa_pkg::PPP_W-1:0];
        end else begin
          tf_reg = cfg_data[pfa_pkg::TF_W-1:0];
          refill_free_list();
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == pfa_pkg::CMD_ALLOC) n_alloc++;
        else n_free++;
        first = frame_reports_due.size();
        predict_frame_moves(s_tuser[0], s_tdata[pfa_pkg::PID_IN_W-1:0]);
        if (cur_typed) begin
          want        = frame_reports_due[first];
          want.status = cur_st;
          want.frame  = cur_fr;
          frame_reports_due[first] = want;
        end
      end
    end
  end

  // receiver with random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    // also covers the fill pass after reset or a total_frames write
    while (frame_reports_due.size() != 0 || !s_tready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pfa_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [pfa_pkg::CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  task automatic send_request(input logic cmd, input logic [5:0] pid, input logic typed,
                              input logic [pfa_pkg::STATUS_W-1:0] st,
                              input logic [7:0] fr);
    if (idling && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tdata   <= {{(pfa_pkg::S_TDATA_W - pfa_pkg::PID_IN_W){1'b0}}, pid};
    s_tuser   <= cmd;
    cur_typed <= typed;
    cur_st    <= st;
    cur_fr    <= fr;
    do @(posedge clk); while (!s_tready);
  endtask

  initial begin
    int pool_base;
    int pool_size;
    int pick;
    int pid;
    logic [pfa_pkg::CFG_DATA_W-1:0] val;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_tab[r].kind == ROW_CFG) begin
        write_reg(dir_tab[r].sel, dir_tab[r].value[pfa_pkg::CFG_DATA_W-1:0]);
      end else begin
        send_request(dir_tab[r].sel, dir_tab[r].value[5:0], dir_tab[r].typed,
                     dir_tab[r].st, dir_tab[r].fr);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      pick = $urandom_range(0, 3);
      if (pick != 1) begin
        case ($urandom_range(0, 5))
          0: val = 9'd0;
          1: val = 9'd31;
          2: val = 9'd16;
          3: val = 9'd1;
          default: val = 9'($urandom_range(0, 31));
        endcase
        write_reg(pfa_pkg::CFG_PAGES_PER_PROCESS, val);
      end
      if (pick != 0) begin
        case ($urandom_range(0, 4))
          0: val = 9'd256;
          1: val = 9'($urandom_range(257, 511));
          2: val = 9'($urandom_range(0, 8));
          default: val = 9'($urandom_range(9, 96));
        endcase
        write_reg(pfa_pkg::CFG_TOTAL_FRAMES, val);
      end
      // a small pool of slots keeps residency churning
      pool_base = $urandom_range(0, PROCESSES - 1);
      pool_size = $urandom_range(3, 12);
      if (ph == PHASES - 1) idling = 1'b0;
      for (int k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
        if ($urandom_range(0, 3) != 0) begin
          pid = (pool_base + $urandom_range(0, pool_size - 1)) % PROCESSES;
        end else begin
          pid = $urandom_range(0, PROCESSES - 1);
        end
        send_request(1'($urandom_range(0, 1)), pid[5:0], 1'b0,
                     pfa_pkg::STAT_GRANTED, 8'd0);
      end
    end

    s_tvalid <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (frame_reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d allocate, %0d free), %0d register writes, %0d results",
             n_alloc + n_free, n_alloc, n_free, n_cfg, n_checked);
    $display("statuses seen: granted %0d, resident %0d, no space %0d, freed %0d, not resident %0d",
             stat_seen[pfa_pkg::STAT_GRANTED], stat_seen[pfa_pkg::STAT_RESIDENT],
             stat_seen[pfa_pkg::STAT_NO_SPACE], stat_seen[pfa_pkg::STAT_FREED],
             stat_seen[pfa_pkg::STAT_NOT_RESIDENT]);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d result items still expected", frame_reports_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
